// ===== rtl/core/ecm_reply_control_word_extractor_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef ECM_REPLY_CONTROL_WORD_EXTRACTOR_DEFINES_SVH
`define ECM_REPLY_CONTROL_WORD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ECMX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ECMX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ecmx_pkg.sv =====
`timescale 1ns / 1ps

package ecmx_pkg;

    // request kinds
    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // record walk phases
    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [7:0] TAG_CW     = 8'h25;
    localparam logic [7:0] MIN_CW_LEN = 8'h0D;
    localparam logic [7:0] SLOT_POS   = 8'd2;
    localparam logic [7:0] SLOT_MASK  = 8'hFE;
    localparam logic [7:0] CW_FIRST   = 8'd5;
    localparam logic [7:0] CW_LAST    = 8'd12;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last_of_reply;
    } t_ecmx_item;

    typedef struct packed {
        logic       cw_valid;
        logic       cw_slot;
        logic [2:0] cw_offset;
        logic [7:0] cw_byte;
        logic [1:0] found_mask;
        logic       ecm_ok;
    } t_ecmx_result;

endpackage

// ===== rtl/core/ecmx_walker.sv =====
`timescale 1ns / 1ps

// TLV record walker: holds the walk state, works out one result per item.
module ecmx_walker import ecmx_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  t_ecmx_item   i_item,
    output t_ecmx_result o_result
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_tag, n_tag;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pos, n_pos;
    logic       r_cap_slot, n_cap_slot;
    logic       r_cap_en, n_cap_en;
    logic [1:0] r_found, n_found;

    logic       qualify;
    logic       in_window;
    logic [8:0] pos_inc;

    assign qualify   = (r_tag == TAG_CW) && (r_len >= MIN_CW_LEN) && (r_pos == SLOT_POS)
                       && ((i_item.data_byte & SLOT_MASK) == 8'd0);
    assign in_window = (r_pos >= CW_FIRST) && (r_pos <= CW_LAST);
    assign pos_inc   = {1'b0, r_pos} + 9'd1;

    always_comb begin
        logic restart;
        logic slot_eff;
        restart    = 1'b0;
        slot_eff   = r_cap_slot;
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_len      = r_len;
        n_pos      = r_pos;
        n_cap_slot = r_cap_slot;
        n_cap_en   = r_cap_en;
        n_found    = r_found;
        o_result   = '0;

        case (i_item.req_type)
            REQ_BEGIN: begin
                n_found = 2'b00;
                restart = 1'b1;
            end
            REQ_FINISH: begin
                restart         = 1'b1;
                o_result.ecm_ok = (r_found == 2'b11);
            end
            REQ_DATA: begin
                case (r_phase)
                    PH_TAG: begin
                        n_tag   = i_item.data_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_len    = i_item.data_byte;
                        n_pos    = 8'd0;
                        n_cap_en = 1'b0;
                        n_phase  = (i_item.data_byte != 8'd0) ? PH_BODY : PH_TAG;
                    end
                    PH_BODY: begin
                        if (qualify) begin
                            slot_eff   = i_item.data_byte[0];
                            n_cap_slot = i_item.data_byte[0];
                            n_cap_en   = 1'b1;
                            n_found    = r_found | (2'b01 << i_item.data_byte[0]);
                        end
                        if ((r_cap_en || qualify) && in_window) begin
                            o_result.cw_valid  = 1'b1;
                            o_result.cw_slot   = slot_eff;
                            o_result.cw_offset = r_pos[2:0] - CW_FIRST[2:0];
                            o_result.cw_byte   = i_item.data_byte;
                        end
                        n_pos = pos_inc[7:0];
                        if (pos_inc >= {1'b0, r_len}) begin
                            n_phase  = PH_TAG;
                            n_cap_en = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_TAG;
                    end
                endcase
                restart = i_item.last_of_reply;
            end
            default: begin
            end
        endcase

        if (restart) begin
            n_phase    = PH_TAG;
            n_tag      = 8'd0;
            n_len      = 8'd0;
            n_pos      = 8'd0;
            n_cap_slot = 1'b0;
            n_cap_en   = 1'b0;
        end
        o_result.found_mask = n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_tag      <= 8'd0;
            r_len      <= 8'd0;
            r_pos      <= 8'd0;
            r_cap_slot <= 1'b0;
            r_cap_en   <= 1'b0;
            r_found    <= 2'b00;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_cap_slot <= n_cap_slot;
            r_cap_en   <= n_cap_en;
            r_found    <= n_found;
        end
    end

endmodule

// ===== rtl/core/ecm_reply_control_word_extractor.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | Signals                      | Contents
// ----------+-----+------------------------------+-----------------------------------------
// s_axis    | in  | tvalid/tready/tdata/tuser/tlast | request kind, reply byte, end of reply
// m_axis    | out | tvalid/tready/tdata/tuser    | control word byte, found mask, ecm ok
//
// One transaction in, one transaction out, one per cycle sustained while m_axis is ready.
// Path: input register, then walker logic into the result register.
// Walk state is updated as an item moves from the input to the result register.
// Reset (i_rst_n low, synchronous) clears the walk state, found mask and both valids.
// A stall on m_axis holds the result; the input register still fills, then s_axis stalls.
module ecm_reply_control_word_extractor import ecmx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        s_axis_tlast,   // last_of_reply

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] cw_offset, [10:3] cw_byte,
                                        // [12:11] found_mask, [13] ecm_ok, [15:14] zero
    output logic [1:0]  m_axis_tuser    // [0] cw_valid, [1] cw_slot
);

    // input register
    logic         r_in_valid;
    t_ecmx_item   r_in;

    // result register
    logic         r_out_valid;
    t_ecmx_result r_out;

    t_ecmx_result walk_res;
    logic         out_free;
    logic         advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    ecmx_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (walk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type      <= s_axis_tuser;
            r_in.data_byte     <= s_axis_tdata;
            r_in.last_of_reply <= s_axis_tlast;
        end
        if (advance) begin
            r_out <= walk_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.cw_slot, r_out.cw_valid};
    assign m_axis_tdata  = {2'b00, r_out.ecm_ok, r_out.found_mask,
                            r_out.cw_byte, r_out.cw_offset};

endmodule

// ===== rtl/core/ecmx_checker.sv =====
`timescale 1ns / 1ps
`include "ecm_reply_control_word_extractor_defines.svh"

// Port-level checks on the result stream.
module ecmx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic        out_stall;
    logic        out_idle;
    logic        out_cw;
    logic        out_ok;
    logic [17:0] out_word;
    logic        cw_fields_clear;
    logic        ok_fields_good;
    logic        cw_slot_marked;

    assign out_stall       = m_axis_tvalid && !m_axis_tready;
    assign out_word        = {m_axis_tuser, m_axis_tdata};
    assign out_idle        = m_axis_tvalid && !m_axis_tuser[0];
    assign out_cw          = m_axis_tvalid && m_axis_tuser[0];
    assign out_ok          = m_axis_tvalid && m_axis_tdata[13];
    assign cw_fields_clear = !m_axis_tuser[1] && (m_axis_tdata[10:0] == 11'd0);
    assign ok_fields_good  = (m_axis_tdata[12:11] == 2'b11) && !m_axis_tuser[0];
    // found bit of the slot named by cw_slot, pad bits clear
    assign cw_slot_marked  = (m_axis_tuser[1] ? m_axis_tdata[12] : m_axis_tdata[11])
                             && (m_axis_tdata[15:14] == 2'b00);

    `ECMX_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stall not held")
    `ECMX_ASSERT_NOW(a_idle_fields_zero, out_idle, cw_fields_clear, "cw fields without cw_valid")
    `ECMX_ASSERT_NOW(a_ok_needs_both, out_ok, ok_fields_good, "ecm_ok without both slots found")
    `ECMX_ASSERT_NOW(a_cw_slot_found, out_cw, cw_slot_marked, "cw byte for unfound slot")

endmodule

bind ecm_reply_control_word_extractor ecmx_checker u_ecmx_checker (.*);

// ===== tb/ecm_reply_control_word_extractor_tb.sv =====
`timescale 1ns / 1ps

module ecm_reply_control_word_extractor_tb;
    import ecmx_pkg::*;

    // the fourth request kind is not used by the block and must leave it untouched
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int unsigned MAX_PRINTED = 100;

    typedef struct {
        t_ecmx_item  item;
        int unsigned gap;     // idle cycles before the item is offered
        bit          drain;   // hold the item back until every result is in
    } t_reply_txn;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;    // [1:0] req_type
    logic        s_axis_tlast = 1'b0;  // last_of_reply

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [2:0] cw_offset, [10:3] cw_byte,
                                       // [12:11] found_mask, [13] ecm_ok
    logic [1:0]  m_axis_tuser;         // [0] cw_valid, [1] cw_slot

    ecm_reply_control_word_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_reply_txn   pending_txns[$];
    t_ecmx_result cw_results_due[$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;

    // handshake flags: raised at the rising edge, consumed at the falling edge
    bit           in_taken = 1'b0;
    bit           out_taken = 1'b1;

    bit           tx_calm = 1'b0;
    bit           drain_next = 1'b0;
    bit           gap_armed = 1'b0;
    int unsigned  gap_left = 0;
    bit           rx_calm = 1'b0;
    int unsigned  stall_left = 0;

    // record walker state, mirrors the block after reset
    logic [1:0]   walk_phase = PH_TAG;
    logic [7:0]   rec_tag = '0;
    logic [7:0]   rec_len = '0;
    logic [7:0]   body_idx = '0;
    logic         cap_slot = 1'b0;
    logic         cap_on = 1'b0;
    logic [1:0]   slots_seen = '0;

    task automatic restart_walk();
        walk_phase = PH_TAG;
        rec_tag    = '0;
        rec_len    = '0;
        body_idx   = '0;
        cap_slot   = 1'b0;
        cap_on     = 1'b0;
    endtask

    // Advances the walker by one request and gives the result it must produce.
    task automatic step_cw_walker(input t_ecmx_item it, output t_ecmx_result r);
        logic [8:0] pos;
        logic [7:0] b;
        r = '0;
        b = it.data_byte;
        case (it.req_type)
            REQ_BEGIN: begin
                slots_seen = '0;
                restart_walk();
            end
            REQ_FINISH: begin
                restart_walk();
                r.ecm_ok = (slots_seen == 2'b11);
            end
            REQ_DATA: begin
                if (walk_phase == PH_TAG) begin
                    rec_tag    = b;
                    walk_phase = PH_LEN;
                end else if (walk_phase == PH_LEN) begin
                    rec_len    = b;
                    body_idx   = '0;
                    cap_on     = 1'b0;
                    walk_phase = (b != 8'd0) ? PH_BODY : PH_TAG;
                end else begin
                    pos = {1'b0, body_idx};
                    // slot byte qualifies the record; found bit is set straight away
                    if (rec_tag == TAG_CW && rec_len >= MIN_CW_LEN && pos == SLOT_POS &&
                        (b & SLOT_MASK) == 8'd0) begin
                        cap_slot         = b[0];
                        cap_on           = 1'b1;
                        slots_seen[b[0]] = 1'b1;
                    end
                    if (cap_on && pos >= CW_FIRST && pos <= CW_LAST) begin
                        r.cw_valid  = 1'b1;
                        r.cw_slot   = cap_slot;
                        r.cw_offset = 3'(pos - CW_FIRST);
                        r.cw_byte   = b;
                    end
                    pos      = pos + 9'd1;
                    body_idx = pos[7:0];
                    if (pos >= rec_len) begin
                        walk_phase = PH_TAG;
                        cap_on     = 1'b0;
                    end
                end
                if (it.last_of_reply)
                    restart_walk();
            end
            default: ;  // spare kind: state held
        endcase
        r.found_mask = slots_seen;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
                     $time, what, got, want, results_seen);
    endtask

    task automatic add_item(input logic [1:0] kind, input logic [7:0] b, input logic last);
        t_reply_txn t;
        t.item.req_type      = kind;
        t.item.data_byte     = b;
        t.item.last_of_reply = last;
        t.gap   = tx_calm ? 0 : $urandom_range(0, 14);
        t.drain = drain_next || ($urandom_range(0, 149) == 0);
        drain_next = 1'b0;
        pending_txns.push_back(t);
    endtask

    // one reply: the last byte carries the end-of-reply mark
    task automatic push_reply(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            add_item(REQ_DATA, bytes[i], i == bytes.size() - 1);
    endtask

    // Sender: offers queued transactions after their gap, holds until accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_taken || !s_axis_tvalid) begin
            in_taken = 1'b0;
            if (!gap_armed && pending_txns.size() > 0) begin
                gap_left  = pending_txns[0].gap;
                gap_armed = 1'b1;
            end
            if (pending_txns.size() == 0 || gap_left > 0 ||
                (pending_txns[0].drain && cw_results_due.size() > 0)) begin
                if (gap_left > 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                s_axis_tuser  <= 2'($urandom);
                s_axis_tlast  <= 1'($urandom);
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_txns[0].item.data_byte;
                s_axis_tuser  <= pending_txns[0].item.req_type;
                s_axis_tlast  <= pending_txns[0].item.last_of_reply;
                void'(pending_txns.pop_front());
                gap_armed = 1'b0;
            end
        end
    end

    // Receiver: a fresh stall is drawn after every accepted result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                out_taken  = 1'b0;
                stall_left = rx_calm ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 99) == 0)
                    rx_calm = !rx_calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on input transactions, checks output transactions.
    always @(posedge i_clk) begin
        t_ecmx_item   it;
        t_ecmx_result want;
        t_ecmx_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken         = 1'b1;
                it.req_type      = s_axis_tuser;
                it.data_byte     = s_axis_tdata;
                it.last_of_reply = s_axis_tlast;
                step_cw_walker(it, want);
                cw_results_due.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_taken      = 1'b1;
                got.cw_valid   = m_axis_tuser[0];
                got.cw_slot    = m_axis_tuser[1];
                got.cw_offset  = m_axis_tdata[2:0];
                got.cw_byte    = m_axis_tdata[10:3];
                got.found_mask = m_axis_tdata[12:11];
                got.ecm_ok     = m_axis_tdata[13];
                if (cw_results_due.size() == 0) begin
                    report_mismatch("unexpected result",
                                    32'({m_axis_tuser, m_axis_tdata}), 0);
                end else begin
                    want = cw_results_due.pop_front();
                    if (got.cw_valid !== want.cw_valid)
                        report_mismatch("cw_valid", 32'(got.cw_valid), 32'(want.cw_valid));
                    if (got.cw_slot !== want.cw_slot)
                        report_mismatch("cw_slot", 32'(got.cw_slot), 32'(want.cw_slot));
                    if (got.cw_offset !== want.cw_offset)
                        report_mismatch("cw_offset", 32'(got.cw_offset),
                                        32'(want.cw_offset));
                    if (got.cw_byte !== want.cw_byte)
                        report_mismatch("cw_byte", 32'(got.cw_byte), 32'(want.cw_byte));
                    if (got.found_mask !== want.found_mask)
                        report_mismatch("found_mask", 32'(got.found_mask),
                                        32'(want.found_mask));
                    if (got.ecm_ok !== want.ecm_ok)
                        report_mismatch("ecm_ok", 32'(got.ecm_ok), 32'(want.ecm_ok));
                end
                results_seen++;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] rb[$];
        int unsigned len;
        logic [7:0]  tag;
        logic [7:0]  slot_byte;

        // directed: spare kind, begin, finish with nothing found
        add_item(REQ_SPARE, 8'hFF, 1'b1);
        add_item(REQ_BEGIN, 8'h00, 1'b0);
        add_item(REQ_FINISH, 8'hA5, 1'b1);
        // zero-length record, then a minimum-length slot 1 record ending the reply
        rb = '{8'h00, 8'h00, TAG_CW, MIN_CW_LEN, 8'hFF, 8'h00, 8'h01, 8'h5A, 8'hC3,
               8'hFF, 8'h00, 8'h80, 8'h01, 8'h7E, 8'h55, 8'hAA, 8'h12};
        push_reply(rb);
        // slot 0 qualified, then the reply is cut before any control word byte
        rb = '{TAG_CW, 8'hFF, 8'h00, 8'h00, 8'h00};
        push_reply(rb);
        add_item(REQ_FINISH, 8'h00, 1'b0);

        // random ECM exchanges, with some noise in between
        drain_next = 1'b1;
        while (pending_txns.size() < 1830) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end else begin
                if ($urandom_range(0, 7) != 0)
                    add_item(REQ_BEGIN, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 3)) begin
                    rb = {};
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 9) < 6) begin
                            // control word record, now and then too short or very long
                            case ($urandom_range(0, 19))
                                0:       len = 255;
                                1:       len = MIN_CW_LEN - 1;
                                default: len = $urandom_range(MIN_CW_LEN, MIN_CW_LEN + 5);
                            endcase
                            tag       = TAG_CW;
                            slot_byte = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(0, 1));
                        end else begin
                            len       = $urandom_range(0, 5);
                            tag       = ($urandom_range(0, 3) == 0) ? TAG_CW : 8'($urandom);
                            slot_byte = 8'($urandom_range(0, 1));
                        end
                        rb.push_back(tag);
                        rb.push_back(8'(len));
                        for (int i = 0; i < len; i++)
                            rb.push_back((i == SLOT_POS) ? slot_byte : 8'($urandom));
                    end
                    if ($urandom_range(0, 6) == 0)
                        rb = rb[0:$urandom_range(0, rb.size() - 1)];
                    push_reply(rb);
                end
                repeat ($urandom_range(1, 2))
                    add_item(REQ_FINISH, 8'($urandom), 1'($urandom));
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_txns.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        while (cw_results_due.size() != 0)
            @(negedge i_clk);
        // spare cycles at the end catch any stray result
        repeat (20) @(negedge i_clk);
        if (cw_results_due.size() != 0)
            report_mismatch("results missing", cw_results_due.size(), 0);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
